>>> rtl/ovl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ovl_pkg: shared definitions for the ordered value list
// Field widths, command and status codes, and the cell control word.
// ----------------------------------------------------------------------------
package ovl_pkg;

	localparam int unsigned DEPTH_DEF = 16;

	localparam int unsigned CMD_W   = 3;
	localparam int unsigned POS_W   = 4;
	localparam int unsigned VALUE_W = 32;
	localparam int unsigned FPOS_W  = 5;
	localparam int unsigned STAT_W  = 2;
	localparam int unsigned LEN_W   = 5;

	localparam logic [CMD_W-1:0] CMD_APPEND     = 3'd0;
	localparam logic [CMD_W-1:0] CMD_FIND       = 3'd1;
	localparam logic [CMD_W-1:0] CMD_REMOVE_AT  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_REMOVE_VAL = 3'd3;
	localparam logic [CMD_W-1:0] CMD_REPLACE    = 3'd4;

	localparam logic [STAT_W-1:0] STAT_DONE     = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
	localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd2;

	typedef struct packed {
		logic capture;
		logic write;
		logic shift;
	} cell_ctl_t;

endpackage

>>> rtl/ovl_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ovl_req_if: command channel
// Valid/ready channel carrying one command word.
// ----------------------------------------------------------------------------
interface ovl_req_if import ovl_pkg::*; ();
	logic                        valid;
	logic                        ready;
	logic [CMD_W-1:0]            cmd;
	logic [POS_W-1:0]            position;
	logic signed [VALUE_W-1:0]   item_value;

	modport source (output valid, output cmd, output position, output item_value,
		input ready);
	modport sink (input valid, input cmd, input position, input item_value,
		output ready);
endinterface

>>> rtl/ovl_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ovl_rsp_if: result channel
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
interface ovl_rsp_if import ovl_pkg::*; ();
	logic                        valid;
	logic                        ready;
	logic signed [VALUE_W-1:0]   result_value;
	logic [FPOS_W-1:0]           found_position;
	logic [STAT_W-1:0]           status;
	logic [LEN_W-1:0]            list_length;

	modport source (output valid, output result_value, output found_position,
		output status, output list_length, input ready);
	modport sink (input valid, input result_value, input found_position,
		input status, input list_length, output ready);
endinterface

>>> rtl/ovl_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ovl_cell: one list position
// Holds one entry, compares it against the search key, and loads either new
// data or the entry of its right-hand neighbor when the list closes a gap.
// ----------------------------------------------------------------------------
module ovl_cell import ovl_pkg::*; #(
	parameter int unsigned AW    = 4,
	parameter int unsigned INDEX = 0
) (
	input  logic                      clk,
	input  cell_ctl_t                 ctl,
	input  logic [AW-1:0]             sel_idx,
	input  logic signed [VALUE_W-1:0] key,
	input  logic signed [VALUE_W-1:0] wr_value,
	input  logic signed [VALUE_W-1:0] next_value,
	output logic signed [VALUE_W-1:0] value,
	output logic                      hit
);

	logic signed [VALUE_W-1:0] value_q;
	logic                      hit_q;
	logic                      at_sel;
	logic                      past_sel;

	assign at_sel   = (sel_idx == AW'(INDEX));
	assign past_sel = (AW'(INDEX) >= sel_idx);

	always_ff @(posedge clk) begin
		if (ctl.write && at_sel) begin
			value_q <= wr_value;
		end else if (ctl.shift && past_sel) begin
			value_q <= next_value;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			hit_q <= (value_q == key);
		end
	end

	assign value = value_q;
	assign hit   = hit_q;

endmodule

>>> rtl/ordered_value_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_value_list: ordered list of signed 32-bit entries
// Commands arrive on req (valid/ready) and each gives one word on rsp.
// Append, find, remove at position, remove by value and replace at position.
// The list is a row of cells; a removal shifts later cells one step toward
// the head in the apply cycle.
// req.ready is high only while the controller is idle. After a command is
// taken, append, remove-at, replace and unknown commands go to the apply
// cycle directly, where the result word is loaded once the result register
// is free; no new command is taken until that word has been loaded.
// Find and remove-by-value latch all cell compares at acceptance, then walk
// the hit bits one position per cycle, stopping at the matching position
// or at the list length, and then go to the apply cycle.
// The result register holds one word; if rsp stalls, the apply cycle waits
// until the register is free, so no word is lost or repeated.
// Reset empties the list (length 0), returns to idle and clears rsp.valid.
// Cell contents are not reset; only positions below the length are read.
// ----------------------------------------------------------------------------
module ordered_value_list import ovl_pkg::*; #(
	parameter int unsigned DEPTH = DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	ovl_req_if.sink   req,
	ovl_rsp_if.source rsp
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SCAN  = 3'b010,
		ST_APPLY = 3'b100
	} state_t;

	state_t                    state_q;
	logic [CMD_W-1:0]          cmd_q;
	logic [POS_W-1:0]          pos_q;
	logic signed [VALUE_W-1:0] val_q;
	logic [CW-1:0]             scan_q;
	logic [CW-1:0]             at_q;
	logic [CW-1:0]             count_q;

	logic signed [VALUE_W-1:0] out_val_q;
	logic [FPOS_W-1:0]         out_fpos_q;
	logic [STAT_W-1:0]         out_stat_q;
	logic [LEN_W-1:0]          out_len_q;
	logic                      out_valid_q;

	logic signed [VALUE_W-1:0] cell_value [DEPTH];
	logic [DEPTH-1:0]          cell_hit;
	cell_ctl_t                 ctl;
	logic [AW-1:0]             sel_idx;
	logic signed [VALUE_W-1:0] sel_value;

	logic                      req_fire;
	logic                      apply_go;
	logic                      pos_ok;
	logic                      scan_end;
	logic                      scan_hit;

	logic signed [VALUE_W-1:0] nx_val;
	logic [CW-1:0]             nx_fpos;
	logic [STAT_W-1:0]         nx_stat;
	logic [CW-1:0]             nx_count;

	assign req.ready = (state_q == ST_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign apply_go  = (state_q == ST_APPLY) && (!out_valid_q || rsp.ready);
	assign pos_ok    = (32'(pos_q) < 32'(count_q));
	assign scan_end  = (scan_q >= count_q);
	assign scan_hit  = cell_hit[scan_q[AW-1:0]];

	always_comb begin
		case (cmd_q) inside
			CMD_APPEND:                 sel_idx = AW'(count_q);
			CMD_FIND, CMD_REMOVE_VAL:   sel_idx = AW'(at_q);
			default:                    sel_idx = AW'(pos_q);
		endcase
	end

	assign sel_value = cell_value[sel_idx];

	// command decode for the apply cycle
	always_comb begin
		nx_val   = '0;
		nx_fpos  = '0;
		nx_stat  = STAT_DONE;
		nx_count = count_q;
		ctl      = '0;
		ctl.capture = req_fire;
		unique case (cmd_q)
			CMD_APPEND: begin
				if (32'(count_q) < DEPTH) begin
					nx_fpos   = count_q;
					nx_count  = count_q + CW'(1);
					ctl.write = apply_go;
				end else begin
					nx_stat = STAT_FULL;
				end
			end
			CMD_FIND: begin
				nx_fpos = at_q;
				if (at_q >= count_q) begin
					nx_stat = STAT_NOTFOUND;
				end
			end
			CMD_REMOVE_AT: begin
				if (pos_ok) begin
					nx_val    = sel_value;
					nx_fpos   = CW'(pos_q);
					nx_count  = count_q - CW'(1);
					ctl.shift = apply_go;
				end else begin
					nx_stat = STAT_NOTFOUND;
				end
			end
			CMD_REMOVE_VAL: begin
				nx_fpos = at_q;
				if (at_q < count_q) begin
					nx_val    = sel_value;
					nx_count  = count_q - CW'(1);
					ctl.shift = apply_go;
				end else begin
					nx_stat = STAT_NOTFOUND;
				end
			end
			CMD_REPLACE: begin
				if (pos_ok) begin
					nx_val    = sel_value;
					nx_fpos   = CW'(pos_q);
					ctl.write = apply_go;
				end else begin
					nx_stat = STAT_NOTFOUND;
				end
			end
			default: begin
				nx_stat = STAT_NOTFOUND;
			end
		endcase
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [VALUE_W-1:0] neighbor;
		if (i == DEPTH - 1) begin : g_last
			assign neighbor = cell_value[i];
		end else begin : g_mid
			assign neighbor = cell_value[i+1];
		end
		ovl_cell #(
			.AW    (AW),
			.INDEX (i)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.sel_idx    (sel_idx),
			.key        (req.item_value),
			.wr_value   (val_q),
			.next_value (neighbor),
			.value      (cell_value[i]),
			.hit        (cell_hit[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			scan_q  <= '0;
			at_q    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						scan_q <= '0;
						case (req.cmd) inside
							CMD_FIND, CMD_REMOVE_VAL: state_q <= ST_SCAN;
							default:                  state_q <= ST_APPLY;
						endcase
					end
				end
				ST_SCAN: begin
					if (scan_end) begin
						at_q    <= count_q;
						state_q <= ST_APPLY;
					end else if (scan_hit) begin
						at_q    <= scan_q;
						state_q <= ST_APPLY;
					end else begin
						scan_q <= scan_q + CW'(1);
					end
				end
				ST_APPLY: begin
					if (apply_go) begin
						count_q <= nx_count;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			cmd_q <= req.cmd;
			pos_q <= req.position;
			val_q <= req.item_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (apply_go) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (apply_go) begin
			out_val_q  <= nx_val;
			out_fpos_q <= FPOS_W'(nx_fpos);
			out_stat_q <= nx_stat;
			out_len_q  <= LEN_W'(nx_count);
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.result_value   = out_val_q;
	assign rsp.found_position = out_fpos_q;
	assign rsp.status         = out_stat_q;
	assign rsp.list_length    = out_len_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= DEPTH)
		else $error("list length exceeds depth");

	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!apply_go |=> count_q == $past(count_q))
		else $error("list length changed outside apply");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> scan_q <= count_q)
		else $error("scan ran past list end");

	a_apply_word: assert property (@(posedge clk) disable iff (!arst_n)
		apply_go |=> rsp.valid && state_q == ST_IDLE)
		else $error("apply did not produce a result word");

endmodule
